// File: sv/zpba_pkg.sv
// Shared constants, codes and types of the zoned page bitmap allocator.
`default_nettype none

package zpba_pkg;

    localparam int NUM_PAGES  = 16384;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);

    // Configuration registers are 15 bits so that they can hold NUM_PAGES itself.
    localparam int REG_W      = 15;
    localparam int OP_W       = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [REG_W-1:0] NUM_PAGES_R            = REG_W'(NUM_PAGES);
    localparam logic [REG_W-1:0] MEMORY_PAGES_RESET     = REG_W'(16384);
    localparam logic [REG_W-1:0] HIGH_ZONE_START_RESET  = REG_W'(4096);
    localparam logic [REG_W-1:0] LOW_ZONE_START_RESET   = REG_W'(256);

    localparam logic [1:0] REG_MEMORY_PAGES    = 2'd0;
    localparam logic [1:0] REG_HIGH_ZONE_START = 2'd1;
    localparam logic [1:0] REG_LOW_ZONE_START  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_ANY  = 3'd0,
        OP_ALLOC_HIGH = 3'd1,
        OP_ALLOC_LOW  = 3'd2,
        OP_FREE       = 3'd3,
        OP_RESERVE    = 3'd4,
        OP_QUERY      = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ZONE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [REG_W-1:0] memory_pages;
        logic [REG_W-1:0] high_zone_start;
        logic [REG_W-1:0] low_zone_start;
    } cfg_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              ok;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } status_t;

    typedef struct packed {
        logic                  wr_en;
        logic [WORD_IDX_W-1:0] wr_addr;
        logic [WORD_BITS-1:0]  wr_data;
        logic                  rd_en;
        logic [WORD_IDX_W-1:0] rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

// File: sv/zpba_bitmap_ram.sv
// Bitmap memory: one used bit per page, one write port and one registered read port.
`default_nettype none

module zpba_bitmap_ram (
    input  wire logic                             clk,
    input  wire zpba_pkg::ram_req_t               req,
    output logic [zpba_pkg::WORD_BITS-1:0]        rd_data
);

    logic [zpba_pkg::WORD_BITS-1:0] mem [zpba_pkg::NUM_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/zpba_scan_unit.sv
// Find-first-free unit: lowest free bit of one bitmap word inside the zone bounds.
`default_nettype none

module zpba_scan_unit (
    input  wire logic [zpba_pkg::WORD_BITS-1:0]  data,
    input  wire logic [zpba_pkg::WORD_IDX_W-1:0] word,
    input  wire logic [zpba_pkg::PAGE_W-1:0]     first_page,
    input  wire logic [zpba_pkg::PAGE_W-1:0]     last_page,
    output logic                                 found,
    output logic [zpba_pkg::BIT_W-1:0]           bit_index
);

    logic [zpba_pkg::WORD_BITS-1:0] lo_mask;
    logic [zpba_pkg::WORD_BITS-1:0] hi_mask;
    logic [zpba_pkg::WORD_BITS-1:0] cand;
    logic [zpba_pkg::WORD_BITS-1:0] lowest;
    logic [zpba_pkg::BIT_W-1:0]     last_bit;

    assign last_bit = last_page[zpba_pkg::BIT_W-1:0];

    always_comb
    begin
        lo_mask = '1;
        hi_mask = '1;
        // Only the first and last words of the zone are cut at the zone bounds.
        if (word == first_page[zpba_pkg::PAGE_W-1:zpba_pkg::BIT_W])
        begin
            lo_mask = {zpba_pkg::WORD_BITS{1'b1}} << first_page[zpba_pkg::BIT_W-1:0];
        end
        if (word == last_page[zpba_pkg::PAGE_W-1:zpba_pkg::BIT_W])
        begin
            hi_mask = {zpba_pkg::WORD_BITS{1'b1}}
                      >> (zpba_pkg::BIT_W'(zpba_pkg::WORD_BITS - 1) - last_bit);
        end
        cand   = ~data & lo_mask & hi_mask;
        lowest = cand & (~cand + zpba_pkg::WORD_BITS'(1));
        found  = |cand;
        bit_index = '0;
        for (int i = 0; i < zpba_pkg::WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                bit_index = bit_index | zpba_pkg::BIT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/zpba_seq.sv
// Sequencer: clearing pass, zone setup, word-by-word bitmap scan and single-page updates.
`default_nettype none

module zpba_seq (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire zpba_pkg::cfg_t                  cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [zpba_pkg::OP_W-1:0]       in_op,
    input  wire logic [zpba_pkg::PAGE_W-1:0]     in_page,
    output logic                                 res_valid,
    input  wire logic                            res_take,
    output zpba_pkg::result_t                    res,
    output zpba_pkg::status_t                    status,
    output zpba_pkg::ram_req_t                   ram_req,
    input  wire logic [zpba_pkg::WORD_BITS-1:0]  rd_data
);

    zpba_pkg::state_t                state_reg, state_next;
    logic [zpba_pkg::OP_W-1:0]       op_reg, op_next;
    logic [zpba_pkg::PAGE_W-1:0]     idx_reg, idx_next;
    logic                            high_reg, high_next;
    logic [zpba_pkg::WORD_IDX_W-1:0] word_reg, word_next;
    logic [zpba_pkg::PAGE_W-1:0]     first_reg, first_next;
    logic [zpba_pkg::PAGE_W-1:0]     last_reg, last_next;
    zpba_pkg::result_t               res_reg, res_next;

    logic [zpba_pkg::REG_W-1:0]      high_limit;
    logic [zpba_pkg::REG_W-1:0]      low_cap;
    logic [zpba_pkg::REG_W-1:0]      low_limit;
    logic [zpba_pkg::REG_W-1:0]      zone_lo;
    logic [zpba_pkg::REG_W-1:0]      zone_hi;
    logic [zpba_pkg::REG_W-1:0]      zone_last;
    logic                            zone_empty;
    logic                            scan_found;
    logic [zpba_pkg::BIT_W-1:0]      scan_bit;
    logic [zpba_pkg::BIT_W-1:0]      idx_bit;
    logic [zpba_pkg::WORD_BITS-1:0]  idx_mask;
    logic [zpba_pkg::WORD_BITS-1:0]  scan_mask;
    logic                            is_alloc;

    zpba_scan_unit u_scan (
        .data       (rd_data),
        .word       (word_reg),
        .first_page (first_reg),
        .last_page  (last_reg),
        .found      (scan_found),
        .bit_index  (scan_bit)
    );

    assign idx_bit   = idx_reg[zpba_pkg::BIT_W-1:0];
    assign idx_mask  = zpba_pkg::WORD_BITS'(1) << idx_bit;
    assign scan_mask = zpba_pkg::WORD_BITS'(1) << scan_bit;
    assign is_alloc  = (op_reg == zpba_pkg::OP_ALLOC_ANY) || (op_reg == zpba_pkg::OP_ALLOC_HIGH)
                       || (op_reg == zpba_pkg::OP_ALLOC_LOW);

    // Zone bounds, both limits clamped to the size of the bitmap.
    always_comb
    begin
        high_limit = (cfg.memory_pages > zpba_pkg::NUM_PAGES_R) ? zpba_pkg::NUM_PAGES_R
                                                                : cfg.memory_pages;
        low_cap    = (cfg.high_zone_start > cfg.memory_pages) ? cfg.memory_pages
                                                              : cfg.high_zone_start;
        low_limit  = (low_cap > zpba_pkg::NUM_PAGES_R) ? zpba_pkg::NUM_PAGES_R : low_cap;
        zone_lo    = high_reg ? cfg.high_zone_start : cfg.low_zone_start;
        zone_hi    = high_reg ? high_limit : low_limit;
        zone_empty = zone_lo >= zone_hi;
        zone_last  = zone_hi - zpba_pkg::REG_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zpba_pkg::ST_CLEAR;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        high_reg  <= high_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        high_next  = high_reg;
        word_next  = word_reg;
        first_next = first_reg;
        last_next  = last_reg;
        res_next   = res_reg;
        ram_req    = '0;

        unique case (state_reg)
            zpba_pkg::ST_CLEAR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = word_reg;
                ram_req.wr_data = '0;
                if (word_reg == zpba_pkg::WORD_IDX_W'(zpba_pkg::NUM_WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = zpba_pkg::ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + zpba_pkg::WORD_IDX_W'(1);
                end
            end

            zpba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_op;
                    idx_next = in_page;
                    res_next = '0;
                    unique case (in_op)
                        zpba_pkg::OP_ALLOC_ANY, zpba_pkg::OP_ALLOC_HIGH:
                        begin
                            high_next  = 1'b1;
                            state_next = zpba_pkg::ST_ZONE;
                        end
                        zpba_pkg::OP_ALLOC_LOW:
                        begin
                            high_next  = 1'b0;
                            state_next = zpba_pkg::ST_ZONE;
                        end
                        zpba_pkg::OP_FREE, zpba_pkg::OP_RESERVE, zpba_pkg::OP_QUERY:
                        begin
                            word_next  = in_page[zpba_pkg::PAGE_W-1:zpba_pkg::BIT_W];
                            state_next = zpba_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = zpba_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            zpba_pkg::ST_ZONE:
            begin
                if (zone_empty)
                begin
                    // Alloc-any falls back to the low zone when the high zone is empty.
                    if (high_reg && (op_reg == zpba_pkg::OP_ALLOC_ANY))
                    begin
                        high_next = 1'b0;
                    end
                    else
                    begin
                        state_next = zpba_pkg::ST_DONE;
                    end
                end
                else
                begin
                    first_next = zone_lo[zpba_pkg::PAGE_W-1:0];
                    last_next  = zone_last[zpba_pkg::PAGE_W-1:0];
                    word_next  = zone_lo[zpba_pkg::PAGE_W-1:zpba_pkg::BIT_W];
                    state_next = zpba_pkg::ST_READ;
                end
            end

            zpba_pkg::ST_READ:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = word_reg;
                state_next      = zpba_pkg::ST_CHECK;
            end

            zpba_pkg::ST_CHECK:
            begin
                ram_req.wr_addr = word_reg;
                if (is_alloc)
                begin
                    if (scan_found)
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_data = rd_data | scan_mask;
                        res_next.page   = {word_reg, scan_bit};
                        res_next.ok     = 1'b1;
                        state_next      = zpba_pkg::ST_DONE;
                    end
                    else if (word_reg == last_reg[zpba_pkg::PAGE_W-1:zpba_pkg::BIT_W])
                    begin
                        if (high_reg && (op_reg == zpba_pkg::OP_ALLOC_ANY))
                        begin
                            high_next  = 1'b0;
                            state_next = zpba_pkg::ST_ZONE;
                        end
                        else
                        begin
                            state_next = zpba_pkg::ST_DONE;
                        end
                    end
                    else
                    begin
                        word_next  = word_reg + zpba_pkg::WORD_IDX_W'(1);
                        state_next = zpba_pkg::ST_READ;
                    end
                end
                else
                begin
                    state_next = zpba_pkg::ST_DONE;
                    unique case (op_reg)
                        zpba_pkg::OP_FREE:
                        begin
                            // Page zero and pages beyond installed memory are never freed.
                            ram_req.wr_en   = (idx_reg != '0)
                                              && ({1'b0, idx_reg} < cfg.memory_pages);
                            ram_req.wr_data = rd_data & ~idx_mask;
                            res_next.ok     = 1'b1;
                        end
                        zpba_pkg::OP_RESERVE:
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_data = rd_data | idx_mask;
                            res_next.ok     = 1'b1;
                        end
                        default:
                        begin
                            res_next.ok = !rd_data[idx_bit];
                        end
                    endcase
                end
            end

            zpba_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = zpba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = zpba_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready        = (state_reg == zpba_pkg::ST_IDLE);
    assign res_valid       = (state_reg == zpba_pkg::ST_DONE);
    assign res             = res_reg;
    assign status.clearing = (state_reg == zpba_pkg::ST_CLEAR);
    assign status.idle     = (state_reg == zpba_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: sv/zoned_page_bitmap_allocator_top.sv
// Zoned page bitmap allocator: stream ports, APB registers and output register.
//
// Usage: one request word enters on s_axis (operation and page index) and exactly
// one response word leaves on m_axis (result page and ok flag), in request order.
// Registers memory_pages, high_zone_start and low_zone_start are written over APB
// at byte addresses 0, 4 and 8, and are to be written only while the block is
// idle; the block itself does not enforce this. The block takes one request at a
// time. For free, reserve and query, the sequencer reads the page's bitmap word
// (ST_READ), updates or tests it (ST_CHECK) and holds the result in ST_DONE
// until the output register, which drives m_axis_tvalid, takes it. For an
// allocation, zone setup (ST_ZONE) leads to a scan that reads bitmap words
// on the read port and checks each in the find-first-free unit until a free page
// is found or the zone ends; alloc-any falls back to the low zone via ST_ZONE.
// Reset: the bitmap is cleared to all free by a pass that writes one word per
// cycle through all 512 words, with s_axis_tready low; APB writes are taken.
// Stall: the response sits in an output register; the next request is accepted
// while it waits, and its own response is held in the sequencer until the output
// register is taken by the receiver.
`default_nettype none

module zoned_page_bitmap_allocator_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // APB configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [zpba_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [zpba_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [zpba_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    // Request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [23:0]                       s_axis_tdata,  // operation[2:0], page_index[16:3]
    // Response stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [15:0]                            m_axis_tdata   // result_page[13:0], ok[14]
);

    zpba_pkg::cfg_t                  cfg_reg;
    logic                            apb_write;
    logic [1:0]                      reg_index;

    logic                            res_valid;
    logic                            res_take;
    zpba_pkg::result_t               res;
    zpba_pkg::status_t               status;
    zpba_pkg::ram_req_t              ram_req;
    logic [zpba_pkg::WORD_BITS-1:0]  rd_data;

    logic                            out_valid_reg;
    zpba_pkg::result_t               out_reg;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.memory_pages    <= zpba_pkg::MEMORY_PAGES_RESET;
            cfg_reg.high_zone_start <= zpba_pkg::HIGH_ZONE_START_RESET;
            cfg_reg.low_zone_start  <= zpba_pkg::LOW_ZONE_START_RESET;
        end
        else if (apb_write)
        begin
            unique case (reg_index)
                zpba_pkg::REG_MEMORY_PAGES:
                begin
                    cfg_reg.memory_pages <= pwdata[zpba_pkg::REG_W-1:0];
                end
                zpba_pkg::REG_HIGH_ZONE_START:
                begin
                    cfg_reg.high_zone_start <= pwdata[zpba_pkg::REG_W-1:0];
                end
                zpba_pkg::REG_LOW_ZONE_START:
                begin
                    cfg_reg.low_zone_start <= pwdata[zpba_pkg::REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            zpba_pkg::REG_MEMORY_PAGES:
            begin
                prdata = zpba_pkg::APB_DATA_W'(cfg_reg.memory_pages);
            end
            zpba_pkg::REG_HIGH_ZONE_START:
            begin
                prdata = zpba_pkg::APB_DATA_W'(cfg_reg.high_zone_start);
            end
            zpba_pkg::REG_LOW_ZONE_START:
            begin
                prdata = zpba_pkg::APB_DATA_W'(cfg_reg.low_zone_start);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    zpba_bitmap_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    zpba_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tdata[2:0]),
        .in_page   (s_axis_tdata[16:3]),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .status    (status),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    // The output register is loaded when it is empty or its word leaves this cycle.
    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.ok, out_reg.page};

`ifndef SYNTH
    a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !s_axis_tready)
        else $error("request accepted during the bitmap clearing pass");

    a_one_request_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after a request was accepted");

    a_failed_page_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[14]) |-> (m_axis_tdata[13:0] == '0))
        else $error("response without ok carries a nonzero page");
`endif

endmodule

`default_nettype wire
